@@ rtl/tdss_pkg.sv @@
// Shared constants, types and fixed-point helpers for the tridiagonal solver.
`timescale 1ns / 1ps
package tdss_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DVD_W     = 32 + FRAC_BITS;

  // error codes, smaller nonzero code is more severe
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_PIV  = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_SAT  = 2'd3;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } fix_t;

  // sticky error update
  function automatic logic [1:0] err_merge(input logic [1:0] cur, input logic [1:0] code);
    err_merge = (cur == ERR_NONE || code < cur) ? code : cur;
  endfunction

  // product / 2^FRAC_BITS truncated toward zero, saturated to 32 bits
  function automatic fix_t q_scale(input logic signed [63:0] p);
    logic signed [63:0] bias;
    logic signed [63:0] t;
    fix_t               r;
    bias = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    t = (p + (p[63] ? bias : 64'sd0)) >>> FRAC_BITS;
    if (t > 64'sh0000_0000_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (t < -64'sh0000_0000_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = t[31:0];
    end
    return r;
  endfunction

  // saturating a - b
  function automatic fix_t sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    fix_t        r;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) begin
      r.sat = 1'b1;
      r.val = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.sat = 1'b0;
      r.val = d[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/tdss_div.sv @@
// Radix-2 restoring divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
`timescale 1ns / 1ps
module tdss_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot,
  output logic        sat
);
  import tdss_pkg::*;

  localparam int IT_W = $clog2(DVD_W + 1);

  logic             run_r, run_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [32:0]      dvs_r;
  logic             neg_r;
  logic             done_r, done_nxt;
  logic [31:0]      quot_r, quot_nxt;
  logic             sat_r, sat_nxt;
  logic [32:0]      rem_sh;
  logic [32:0]      num_mag;
  logic [32:0]      den_mag;
  logic [DVD_W-1:0] q_fin;

  assign num_mag = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
  assign den_mag = den[31] ? (33'd0 - {den[31], den}) : {1'b0, den};
  assign rem_sh  = {rem_r[31:0], dvd_r[DVD_W-1]};

  // one quotient bit per cycle, then sign and saturate
  always_comb begin
    run_nxt  = run_r;
    it_nxt   = it_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    sat_nxt  = sat_r;
    q_fin    = dvd_r;
    if (start) begin
      run_nxt = 1'b1;
      it_nxt  = IT_W'(DVD_W);
      dvd_nxt = {num_mag[31:0], {FRAC_BITS{1'b0}}};
      rem_nxt = '0;
    end else if (run_r) begin
      if (rem_sh >= dvs_r) begin
        rem_nxt = rem_sh - dvs_r;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      it_nxt = it_r - IT_W'(1);
      if (it_r == IT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        q_fin    = dvd_nxt;
        if (!neg_r && q_fin > DVD_W'(32'h7FFF_FFFF)) begin
          sat_nxt  = 1'b1;
          quot_nxt = 32'h7FFF_FFFF;
        end else if (neg_r && q_fin > DVD_W'(33'h0_8000_0000)) begin
          sat_nxt  = 1'b1;
          quot_nxt = 32'h8000_0000;
        end else begin
          sat_nxt  = 1'b0;
          quot_nxt = neg_r ? (32'd0 - q_fin[31:0]) : q_fin[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    it_r   <= it_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    sat_r  <= sat_nxt;
    if (start) begin
      dvs_r <= den_mag;
      neg_r <= num[31] ^ den[31];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign sat  = sat_r;

endmodule

@@ rtl/tridiagonal_system_solver_unit.sv @@
// Top level of the Thomas-algorithm tridiagonal solver.
`timescale 1ns / 1ps
// Usage:
//   A row request is taken when start is high and busy is low. Rows come in
//   order, first row first; in_last_row marks the final row of the system.
//   The forward sweep runs per row: two reads of the coefficient memories,
//   two shared multiplies and two 48-step divides; a zero pivot skips the
//   divides, and the first row skips the reads and the multiplies.
//   After the last row, back substitution walks the stored rows from the
//   bottom up, then every solution is sent, last row first. Each result is
//   on out_* for exactly one cycle with out_valid high; the receiver must
//   take it then.
//   out_error_code is the run's sticky code and is the same on all results.
//   A row beyond 64 is dropped and flags a row overflow.
//   Reset (rst_n low, synchronous) clears the row count and error state;
//   the coefficient memories are not cleared and need no clearing pass.
module tridiagonal_system_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_sub_diag,
  input  logic [31:0] in_main_diag,
  input  logic [31:0] in_super_diag,
  input  logic [31:0] in_rhs_value,
  input  logic        in_last_row,
  output logic        out_valid,
  output logic [31:0] out_solution_value,
  output logic [tdss_pkg::ROW_W-1:0] out_row_index,
  output logic [1:0]  out_error_code,
  output logic        out_last_result
);
  import tdss_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FWAIT  = 4'd1;
  localparam logic [3:0] S_FM1    = 4'd2;
  localparam logic [3:0] S_FM2    = 4'd3;
  localparam logic [3:0] S_FM3    = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_DIV1   = 4'd6;
  localparam logic [3:0] S_DIV2   = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_BWAIT0 = 4'd9;
  localparam logic [3:0] S_BLD    = 4'd10;
  localparam logic [3:0] S_BWAIT  = 4'd11;
  localparam logic [3:0] S_BMUL   = 4'd12;
  localparam logic [3:0] S_BSUB   = 4'd13;
  localparam logic [3:0] S_EWAIT  = 4'd14;
  localparam logic [3:0] S_EOUT   = 4'd15;

  // coefficient memories
  logic [31:0] sup_mem [MAX_ROWS];
  logic [31:0] rhs_mem [MAX_ROWS];
  logic [31:0] sup_q, rhs_q;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] rows_r, rows_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [ROW_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [ROW_W-1:0] idx_r, idx_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic        last_r;
  logic [31:0] den_r, den_nxt, num_r, num_nxt;
  logic [31:0] cs_r, cs_nxt, ds_r, ds_nxt;
  logic [31:0] x_r, x_nxt;

  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] prod_r;
  fix_t               scl, dif;

  logic             we_sup, we_rhs;
  logic [ROW_W-1:0] wr_addr;
  logic [31:0]      wr_rhs;

  logic        div_start, div_done, div_sat;
  logic [31:0] div_num, div_q;

  logic        accept;
  logic [ROW_W-1:0] top_row;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign top_row = ROW_W'(rows_r - CNT_W'(1));

  tdss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  assign div_start = ((state_r == S_CHK) && (den_r != 32'd0)) ||
                     ((state_r == S_DIV1) && div_done);
  assign div_num   = (state_r == S_CHK) ? c_r : num_r;

  // shared multiplier operands
  always_comb begin
    mul_x = $signed(a_r);
    mul_y = $signed(sup_q);
    if (state_r == S_FM2) begin
      mul_y = $signed(rhs_q);
    end else if (state_r == S_BMUL) begin
      mul_x = $signed(sup_q);
      mul_y = $signed(x_r);
    end
  end

  // scaled product and the subtraction that follows it
  always_comb begin
    scl = q_scale(prod_r);
    if (state_r == S_FM2) begin
      dif = sat_sub(b_r, scl.val);
    end else if (state_r == S_FM3) begin
      dif = sat_sub(d_r, scl.val);
    end else begin
      dif = sat_sub(rhs_q, scl.val);
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    rows_nxt    = rows_r;
    err_nxt     = err_r;
    rd_addr_nxt = rd_addr_r;
    idx_nxt     = idx_r;
    den_nxt     = den_r;
    num_nxt     = num_r;
    cs_nxt      = cs_r;
    ds_nxt      = ds_r;
    x_nxt       = x_r;
    we_sup      = 1'b0;
    we_rhs      = 1'b0;
    wr_addr     = rows_r[ROW_W-1:0];
    wr_rhs      = ds_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (rows_r == CNT_W'(MAX_ROWS)) begin
            err_nxt = err_merge(err_r, ERR_OVF);
            if (in_last_row) begin
              rd_addr_nxt = top_row;
              state_nxt   = S_BWAIT0;
            end
          end else if (rows_r == '0) begin
            den_nxt   = in_main_diag;
            num_nxt   = in_rhs_value;
            state_nxt = S_CHK;
          end else begin
            rd_addr_nxt = top_row;
            state_nxt   = S_FWAIT;
          end
        end
      end
      S_FWAIT: state_nxt = S_FM1;
      S_FM1:   state_nxt = S_FM2;
      S_FM2: begin
        den_nxt = dif.val;
        if (scl.sat || dif.sat) err_nxt = err_merge(err_r, ERR_SAT);
        state_nxt = S_FM3;
      end
      S_FM3: begin
        num_nxt = dif.val;
        if (scl.sat || dif.sat) err_nxt = err_merge(err_r, ERR_SAT);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (den_r == 32'd0) begin
          err_nxt   = err_merge(err_r, ERR_PIV);
          cs_nxt    = 32'd0;
          ds_nxt    = 32'd0;
          state_nxt = S_WR;
        end else begin
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          cs_nxt = div_q;
          if (div_sat) err_nxt = err_merge(err_r, ERR_SAT);
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          ds_nxt = div_q;
          if (div_sat) err_nxt = err_merge(err_r, ERR_SAT);
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        we_sup   = 1'b1;
        we_rhs   = 1'b1;
        rows_nxt = rows_r + CNT_W'(1);
        if (last_r) begin
          rd_addr_nxt = rows_r[ROW_W-1:0];
          state_nxt   = S_BWAIT0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BWAIT0: state_nxt = S_BLD;
      S_BLD: begin
        x_nxt = rhs_q;
        if (top_row == '0) begin
          idx_nxt   = top_row;
          state_nxt = S_EWAIT;
        end else begin
          idx_nxt     = top_row - ROW_W'(1);
          rd_addr_nxt = top_row - ROW_W'(1);
          state_nxt   = S_BWAIT;
        end
      end
      S_BWAIT: state_nxt = S_BMUL;
      S_BMUL:  state_nxt = S_BSUB;
      S_BSUB: begin
        x_nxt   = dif.val;
        we_rhs  = 1'b1;
        wr_addr = idx_r;
        wr_rhs  = dif.val;
        if (scl.sat || dif.sat) err_nxt = err_merge(err_r, ERR_SAT);
        if (idx_r == '0) begin
          idx_nxt     = top_row;
          rd_addr_nxt = top_row;
          state_nxt   = S_EWAIT;
        end else begin
          idx_nxt     = idx_r - ROW_W'(1);
          rd_addr_nxt = idx_r - ROW_W'(1);
          state_nxt   = S_BWAIT;
        end
      end
      S_EWAIT: state_nxt = S_EOUT;
      S_EOUT: begin
        if (idx_r == '0) begin
          rows_nxt  = '0;
          err_nxt   = ERR_NONE;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt     = idx_r - ROW_W'(1);
          rd_addr_nxt = idx_r - ROW_W'(1);
          state_nxt   = S_EWAIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (we_sup) sup_mem[wr_addr] <= cs_r;
    if (we_rhs) rhs_mem[wr_addr] <= wr_rhs;
    sup_q <= sup_mem[rd_addr_r];
    rhs_q <= rhs_mem[rd_addr_r];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r  <= '0;
      err_r   <= ERR_NONE;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      err_r   <= err_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    idx_r     <= idx_nxt;
    den_r     <= den_nxt;
    num_r     <= num_nxt;
    cs_r      <= cs_nxt;
    ds_r      <= ds_nxt;
    x_r       <= x_nxt;
    prod_r    <= mul_x * mul_y;
    if (accept) begin
      a_r    <= in_sub_diag;
      b_r    <= in_main_diag;
      c_r    <= in_last_row ? 32'd0 : in_super_diag;
      d_r    <= in_rhs_value;
      last_r <= in_last_row;
    end
  end

  assign out_valid          = (state_r == S_EOUT);
  assign out_solution_value = rhs_q;
  assign out_row_index      = idx_r;
  assign out_error_code     = err_r;
  assign out_last_result    = (state_r == S_EOUT) && (idx_r == '0);

endmodule

@@ rtl/tdss_chk.sv @@
// Port-level checker for the tridiagonal solver, bound to the top level.
`timescale 1ns / 1ps
module tdss_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [tdss_pkg::ROW_W-1:0] out_row_index,
  input logic       out_last_result
);
  import tdss_pkg::*;

  // results only come out while a run is in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // end-of-run marker only on a real result for row zero
  a_last_row0: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_result |-> (out_valid && out_row_index == '0))
    else $error("end marker misplaced");

  // with no request an idle block stays idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!start && !busy) |=> !busy) else $error("busy without a request");

  // the run ends after its last result
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=> (!busy && !out_valid))
    else $error("run did not end");

  // results are spaced, never in adjacent cycles
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("results back to back");

endmodule

bind tridiagonal_system_solver_unit tdss_chk u_tdss_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_row_index   (out_row_index),
  .out_last_result (out_last_result)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the tridiagonal system solver unit.
`timescale 1ns / 1ps
module tb_top;
  import tdss_pkg::*;

  typedef struct packed {
    logic [31:0] sub_diag;
    logic [31:0] main_diag;
    logic [31:0] super_diag;
    logic [31:0] rhs_value;
    logic        last_row;
  } row_req_t;

  typedef struct packed {
    logic [31:0]      value;
    logic [ROW_W-1:0] row;
    logic [1:0]       err;
    logic             last;
  } solution_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_sub_diag, in_main_diag, in_super_diag, in_rhs_value;
  logic        in_last_row;
  logic        out_valid;
  logic [31:0] out_solution_value;
  logic [ROW_W-1:0] out_row_index;
  logic [1:0]  out_error_code;
  logic        out_last_result;

  tridiagonal_system_solver_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sub_diag(in_sub_diag), .in_main_diag(in_main_diag),
    .in_super_diag(in_super_diag), .in_rhs_value(in_rhs_value),
    .in_last_row(in_last_row), .out_valid(out_valid),
    .out_solution_value(out_solution_value), .out_row_index(out_row_index),
    .out_error_code(out_error_code), .out_last_result(out_last_result)
  );

  row_req_t  pending_rows[$];
  solution_t expected_solutions[$];
  int        mismatch_count;
  bit        no_idle;
  logic      busy_at_edge;

  // solver state mirrored from the block
  logic signed [31:0] sweep_super[MAX_ROWS];
  logic signed [31:0] sweep_rhs[MAX_ROWS];
  int                 rows_held;
  logic [1:0]         run_err;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_err(input logic [1:0] code);
    if (run_err == ERR_NONE || code < run_err) run_err = code;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      note_err(ERR_SAT);
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      note_err(ERR_SAT);
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
    logic signed [63:0] p;
    p = x * y;
    return clamp32(p / (64'sd1 <<< FRAC_BITS));
  endfunction

  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] den);
    logic signed [63:0] s;
    s = n * (64'sd1 <<< FRAC_BITS);
    return clamp32(s / den);
  endfunction

  // forward sweep per row; back substitution on the last row
  task automatic solve_row(input row_req_t rq);
    logic signed [63:0] a, b, c, d, den, num, cs, ds, x;
    logic signed [31:0] xs[MAX_ROWS];
    solution_t s;
    int r, n;
    a = $signed(rq.sub_diag);
    b = $signed(rq.main_diag);
    c = rq.last_row ? 64'sd0 : $signed(rq.super_diag);
    d = $signed(rq.rhs_value);
    if (rows_held >= MAX_ROWS) begin
      note_err(ERR_OVF);
    end else begin
      r = rows_held;
      if (r == 0) begin
        den = b;
        num = d;
      end else begin
        den = clamp32(b - fx_mul(a, sweep_super[r-1]));
        num = clamp32(d - fx_mul(a, sweep_rhs[r-1]));
      end
      if (den == 0) begin
        note_err(ERR_PIV);
        cs = 0;
        ds = 0;
      end else begin
        cs = fx_div(c, den);
        ds = fx_div(num, den);
      end
      sweep_super[r] = cs[31:0];
      sweep_rhs[r] = ds[31:0];
      rows_held = r + 1;
    end
    if (!rq.last_row) return;
    n = rows_held;
    x = sweep_rhs[n-1];
    xs[n-1] = x[31:0];
    for (int i = n - 2; i >= 0; i--) begin
      x = clamp32(sweep_rhs[i] - fx_mul(sweep_super[i], x));
      xs[i] = x[31:0];
    end
    for (int row = n - 1; row >= 0; row--) begin
      s.value = xs[row];
      s.row = row[ROW_W-1:0];
      s.err = run_err;
      s.last = (row == 0);
      expected_solutions.push_back(s);
    end
    rows_held = 0;
    run_err = ERR_NONE;
  endtask

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic add_row(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                         input logic [31:0] d, input logic last);
    row_req_t rq;
    rq = '{a, b, c, d, last};
    pending_rows.push_back(rq);
  endtask

  // random system: mostly diagonally dominant, some with wild values
  task automatic add_system(input int n);
    logic [31:0] a, b, c, d;
    bit wild;
    wild = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (wild) begin
        a = rnd_coef(); b = rnd_coef(); c = rnd_coef(); d = rnd_coef();
      end else begin
        a = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        c = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        b = $urandom_range(32'h0003_0000, 32'h0010_0000);
        if ($urandom_range(0, 1)) b = -b;
        d = $urandom;
        if ($urandom_range(0, 1)) d = $signed(d) >>> $urandom_range(0, 16);
      end
      add_row(a, b, c, d, i == n - 1);
    end
  endtask

  // driver: changes on falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous request was taken at the last rising edge
      void'(pending_rows.pop_front());
      drive_next();
    end else if (!start) begin
      drive_next();
    end
  end

  always @(posedge clk) busy_at_edge <= busy;

  task automatic drive_next();
    row_req_t rq;
    if (pending_rows.size() == 0 || (!no_idle && $urandom_range(0, 99) < 25)) begin
      start <= 1'b0;
    end else begin
      rq = pending_rows[0];
      start <= 1'b1;
      in_sub_diag <= rq.sub_diag;
      in_main_diag <= rq.main_diag;
      in_super_diag <= rq.super_diag;
      in_rhs_value <= rq.rhs_value;
      in_last_row <= rq.last_row;
    end
  endtask

  // prediction at the accepting edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      solve_row('{in_sub_diag, in_main_diag, in_super_diag, in_rhs_value, in_last_row});
    end
  end

  // monitor
  always @(posedge clk) begin
    solution_t exp_s;
    if (rst_n && out_valid) begin
      if (expected_solutions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected solution row %0d value %h", out_row_index,
                   out_solution_value);
      end else begin
        exp_s = expected_solutions.pop_front();
        if (exp_s != {out_solution_value, out_row_index, out_error_code, out_last_result})
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"solution mismatch: exp val %h row %0d err %0d last %0d, ",
                      "got val %h row %0d err %0d last %0d"},
                     exp_s.value, exp_s.row, exp_s.err, exp_s.last, out_solution_value,
                     out_row_index, out_error_code, out_last_result);
        end
      end
    end
  end

  initial begin
    int drain;
    mismatch_count = 0;
    rows_held = 0;
    run_err = ERR_NONE;
    no_idle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_sub_diag = '0; in_main_diag = '0; in_super_diag = '0; in_rhs_value = '0;
    in_last_row = 1'b0;
    busy_at_edge = 1'b0;

    // directed: single row, extremes, zero pivots, saturation
    add_row(32'h0, 32'h0001_0000, 32'h1234_5678, 32'h0003_0000, 1'b1);
    add_row(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0, 32'hFFFF_0000, 1'b1);
    add_row(32'h1111_1111, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000, 1'b0);
    add_row(32'h0001_0000, 32'h0001_0000, 32'h5555_5555, 32'h0002_0000, 1'b1);
    add_row(32'h0, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_row(32'h0, 32'h0001_0000, 32'h0, 32'h0000_8000, 1'b1);
    // row overflow: 66 rows, two dropped
    for (int i = 0; i < 66; i++)
      add_row($urandom_range(0, 32'hFFFF), 32'h0004_0000, $urandom_range(0, 32'hFFFF),
              $urandom, i == 65);
    // 64-row full system without overflow
    add_system(MAX_ROWS);
    // random systems, mostly small
    while (pending_rows.size() < 360) add_system($urandom_range(1, 8));

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    fork
      begin
        repeat (3000) @(posedge clk);
        no_idle = 1'b1;
        repeat (20000) @(posedge clk);
        no_idle = 1'b0;
      end
    join_none

    wait (pending_rows.size() == 0);
    wait (expected_solutions.size() == 0);
    drain = 0;
    while (drain < 400) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0 && expected_solutions.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // watchdog: a time limit on all rows plus idling, with plenty of margin
  initial begin
    #(8 * 1000000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
